@@ design/e2bv_pkg.sv @@
// shared types, constants and arithmetic helpers for the euler angle to basis vector block
// no dependencies; used by every module of the block
package e2bv_pkg;

   localparam int ANGLE_BITS    = 16;
   localparam int FRAC_BITS     = 14;
   localparam int FIELD_BITS    = 16;
   localparam int CORDIC_STEPS  = 30;
   localparam int NUM_OUT       = 9;
   localparam int IN_BITS       = 3 * FIELD_BITS;
   localparam int OUT_BITS      = NUM_OUT * FIELD_BITS;
   localparam int STEP_BITS     = $clog2(CORDIC_STEPS);
   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

   // one rotation lane: x, y and residual angle, all with a guard bit
   typedef struct packed {
      logic signed [32:0] x;
      logic signed [32:0] y;
      logic signed [32:0] z;
   } cordic_lane_type;

   // one slot of the rotation chain: pitch, yaw, roll lanes and quadrants
   typedef struct packed {
      logic                  valid;
      logic [2:0][1:0]       quad;
      cordic_lane_type [2:0] lane;
   } cordic_slot_type;

   // atan(2^-i) as a fraction of a turn, 2^32 per turn
   function automatic logic signed [32:0] atan_turn(input logic [STEP_BITS-1:0] idx);
      logic signed [32:0] r;
      unique case (idx)
         5'd0:  r = 33'sd536870912;
         5'd1:  r = 33'sd316933406;
         5'd2:  r = 33'sd167458907;
         5'd3:  r = 33'sd85004756;
         5'd4:  r = 33'sd42667331;
         5'd5:  r = 33'sd21354465;
         5'd6:  r = 33'sd10679838;
         5'd7:  r = 33'sd5340245;
         5'd8:  r = 33'sd2670163;
         5'd9:  r = 33'sd1335087;
         5'd10: r = 33'sd667544;
         5'd11: r = 33'sd333772;
         5'd12: r = 33'sd166886;
         5'd13: r = 33'sd83443;
         5'd14: r = 33'sd41722;
         5'd15: r = 33'sd20861;
         5'd16: r = 33'sd10430;
         5'd17: r = 33'sd5215;
         5'd18: r = 33'sd2608;
         5'd19: r = 33'sd1304;
         5'd20: r = 33'sd652;
         5'd21: r = 33'sd326;
         5'd22: r = 33'sd163;
         5'd23: r = 33'sd81;
         5'd24: r = 33'sd41;
         5'd25: r = 33'sd20;
         5'd26: r = 33'sd10;
         5'd27: r = 33'sd5;
         5'd28: r = 33'sd3;
         5'd29: r = 33'sd1;
         default: r = 33'sd0;
      endcase
      return r;
   endfunction

   // q30 product with round half up
   function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      logic signed [63:0] q;
      p = 64'(a) * 64'(b);
      q = (p + 64'sd536870912) >>> 30;
      return q[31:0];
   endfunction

   // q30 to output format: round, saturate to +-1.0, keep the field width
   function automatic logic [FIELD_BITS-1:0] to_out(input logic signed [32:0] v);
      localparam int SH = 30 - FRAC_BITS;
      logic signed [63:0] w;
      logic signed [63:0] r;
      logic signed [63:0] lim;
      w   = 64'(v);
      lim = 64'sd1 <<< FRAC_BITS;
      if (SH > 0) begin
         r = (w + (64'sd1 <<< (SH - 1))) >>> SH;
      end else begin
         r = w;
      end
      if (r > lim) begin
         r = lim;
      end
      if (r < -lim) begin
         r = -lim;
      end
      return r[FIELD_BITS-1:0];
   endfunction

endpackage

@@ design/e2bv_cordic_cell.sv @@
// one rotation step of the cordic chain for the three angles of a request
// depends on e2bv_pkg for the slot type and the arctangent table
module e2bv_cordic_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic [e2bv_pkg::STEP_BITS-1:0]     step,
   input  e2bv_pkg::cordic_slot_type          slot_in,
   output e2bv_pkg::cordic_slot_type          slot_out
);

   e2bv_pkg::cordic_slot_type slot_in_w;
   e2bv_pkg::cordic_slot_type slot_ff;
   logic signed [32:0]        atan_w;

   // rotate each lane toward zero residual
   always_comb begin
      atan_w    = e2bv_pkg::atan_turn(step);
      slot_in_w = slot_in;
      for (int k = 0; k < 3; k++) begin
         if (!slot_in.lane[k].z[32]) begin
            slot_in_w.lane[k].x = slot_in.lane[k].x - (slot_in.lane[k].y >>> step);
            slot_in_w.lane[k].y = slot_in.lane[k].y + (slot_in.lane[k].x >>> step);
            slot_in_w.lane[k].z = slot_in.lane[k].z - atan_w;
         end else begin
            slot_in_w.lane[k].x = slot_in.lane[k].x + (slot_in.lane[k].y >>> step);
            slot_in_w.lane[k].y = slot_in.lane[k].y - (slot_in.lane[k].x >>> step);
            slot_in_w.lane[k].z = slot_in.lane[k].z + atan_w;
         end
      end
   end

   // slot register, valid cleared on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else if (advance) begin
         slot_ff <= slot_in_w;
      end
   end

   assign slot_out = slot_ff;

endmodule

@@ design/e2bv_product.sv @@
// quadrant unfold and product stages forming the nine basis vector components
// depends on e2bv_pkg for the slot type, mulq and to_out
module e2bv_product (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  e2bv_pkg::cordic_slot_type         slot_in,
   output logic                              res_valid,
   output logic [e2bv_pkg::OUT_BITS-1:0]     res_data
);

   logic signed [31:0] sin_w [3];
   logic signed [31:0] cos_w [3];

   logic               q_valid_ff;
   logic signed [31:0] sin_ff [3];
   logic signed [31:0] cos_ff [3];

   logic               a_valid_ff;
   logic signed [31:0] spcy_ff, spsy_ff, cpcy_ff, cpsy_ff, srcp_ff, crcp_ff;
   logic signed [31:0] crsy_ff, srsy_ff, crcy_ff, srcy_ff;
   logic signed [31:0] a_sp_ff, a_sr_ff, a_cr_ff;

   logic               b_valid_ff;
   logic signed [31:0] srspcy_ff, srspsy_ff, crspcy_ff, crspsy_ff;
   logic signed [31:0] b_cpcy_ff, b_cpsy_ff, b_srcp_ff, b_crcp_ff;
   logic signed [31:0] b_crsy_ff, b_srsy_ff, b_crcy_ff, b_srcy_ff, b_sp_ff;

   logic signed [32:0] v_w [e2bv_pkg::NUM_OUT];

   // unfold the quadrant of each angle
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         unique case (slot_in.quad[k])
            2'd0: begin
               sin_w[k] = slot_in.lane[k].y[31:0];
               cos_w[k] = slot_in.lane[k].x[31:0];
            end
            2'd1: begin
               sin_w[k] = slot_in.lane[k].x[31:0];
               cos_w[k] = -slot_in.lane[k].y[31:0];
            end
            2'd2: begin
               sin_w[k] = -slot_in.lane[k].y[31:0];
               cos_w[k] = -slot_in.lane[k].x[31:0];
            end
            default: begin
               sin_w[k] = -slot_in.lane[k].x[31:0];
               cos_w[k] = slot_in.lane[k].y[31:0];
            end
         endcase
      end
   end

   // valid bits of the three stages
   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         q_valid_ff <= slot_in.valid;
         a_valid_ff <= q_valid_ff;
         b_valid_ff <= a_valid_ff;
      end
   end

   // sine/cosine, first products, second products
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            sin_ff[k] <= sin_w[k];
            cos_ff[k] <= cos_w[k];
         end
         spcy_ff <= e2bv_pkg::mulq(sin_ff[0], cos_ff[1]);
         spsy_ff <= e2bv_pkg::mulq(sin_ff[0], sin_ff[1]);
         cpcy_ff <= e2bv_pkg::mulq(cos_ff[0], cos_ff[1]);
         cpsy_ff <= e2bv_pkg::mulq(cos_ff[0], sin_ff[1]);
         srcp_ff <= e2bv_pkg::mulq(sin_ff[2], cos_ff[0]);
         crcp_ff <= e2bv_pkg::mulq(cos_ff[2], cos_ff[0]);
         crsy_ff <= e2bv_pkg::mulq(cos_ff[2], sin_ff[1]);
         srsy_ff <= e2bv_pkg::mulq(sin_ff[2], sin_ff[1]);
         crcy_ff <= e2bv_pkg::mulq(cos_ff[2], cos_ff[1]);
         srcy_ff <= e2bv_pkg::mulq(sin_ff[2], cos_ff[1]);
         a_sp_ff <= sin_ff[0];
         a_sr_ff <= sin_ff[2];
         a_cr_ff <= cos_ff[2];
         srspcy_ff <= e2bv_pkg::mulq(a_sr_ff, spcy_ff);
         srspsy_ff <= e2bv_pkg::mulq(a_sr_ff, spsy_ff);
         crspcy_ff <= e2bv_pkg::mulq(a_cr_ff, spcy_ff);
         crspsy_ff <= e2bv_pkg::mulq(a_cr_ff, spsy_ff);
         b_cpcy_ff <= cpcy_ff;
         b_cpsy_ff <= cpsy_ff;
         b_srcp_ff <= srcp_ff;
         b_crcp_ff <= crcp_ff;
         b_crsy_ff <= crsy_ff;
         b_srsy_ff <= srsy_ff;
         b_crcy_ff <= crcy_ff;
         b_srcy_ff <= srcy_ff;
         b_sp_ff   <= a_sp_ff;
      end
   end

   // final sums and output format
   always_comb begin
      v_w[0] = 33'(b_cpcy_ff);
      v_w[1] = 33'(b_cpsy_ff);
      v_w[2] = -33'(b_sp_ff);
      v_w[3] = 33'(b_crsy_ff) - 33'(srspcy_ff);
      v_w[4] = -33'(srspsy_ff) - 33'(b_crcy_ff);
      v_w[5] = -33'(b_srcp_ff);
      v_w[6] = 33'(crspcy_ff) + 33'(b_srsy_ff);
      v_w[7] = 33'(crspsy_ff) - 33'(b_srcy_ff);
      v_w[8] = 33'(b_crcp_ff);
      for (int k = 0; k < e2bv_pkg::NUM_OUT; k++) begin
         res_data[k*e2bv_pkg::FIELD_BITS +: e2bv_pkg::FIELD_BITS] = e2bv_pkg::to_out(v_w[k]);
      end
   end

   assign res_valid = b_valid_ff;

endmodule

@@ design/euler_to_basis_vectors.sv @@
// euler angles to forward, right and up basis vectors, top level
// pipeline of 30 cordic cells, quadrant unfold, two product stages and an output register
// throughput one request per cycle; the whole pipe holds while a result waits on rsp_tready
// synchronous active-high reset clears all valid bits; data registers are not reset
// depends on e2bv_pkg, e2bv_cordic_cell and e2bv_product
module euler_to_basis_vectors (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // pitch_angle, yaw_angle, roll_angle
   input  logic [e2bv_pkg::IN_BITS-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // fwd_x, fwd_y, fwd_z, right_x, right_y, right_z, up_x, up_y, up_z
   output logic [e2bv_pkg::OUT_BITS-1:0] rsp_tdata
);

   e2bv_pkg::cordic_slot_type             slot_w [e2bv_pkg::CORDIC_STEPS+1];
   logic                                  advance;
   logic [31:0]                           turn_w [3];
   logic                                  res_valid_w;
   logic [e2bv_pkg::OUT_BITS-1:0]         res_data_w;
   logic                                  out_valid_ff;
   logic [e2bv_pkg::OUT_BITS-1:0]         out_data_ff;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   // scale each angle to a 32-bit turn, split quadrant and residual
   always_comb begin
      slot_w[0].valid = req_tvalid;
      for (int k = 0; k < 3; k++) begin
         turn_w[k] = (32'(req_tdata[k*e2bv_pkg::FIELD_BITS +: e2bv_pkg::FIELD_BITS])
                      & e2bv_pkg::ANGLE_MASK) << (32 - e2bv_pkg::ANGLE_BITS);
         slot_w[0].quad[k]   = turn_w[k][31:30];
         slot_w[0].lane[k].x = e2bv_pkg::CORDIC_GAIN;
         slot_w[0].lane[k].y = 33'sd0;
         slot_w[0].lane[k].z = $signed({3'b000, turn_w[k][29:0]});
      end
   end

   // chain of rotation cells
   for (genvar i = 0; i < e2bv_pkg::CORDIC_STEPS; i++) begin : g_cell
      e2bv_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .step     (e2bv_pkg::STEP_BITS'(i)),
         .slot_in  (slot_w[i]),
         .slot_out (slot_w[i+1])
      );
   end

   e2bv_product u_product (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .slot_in   (slot_w[e2bv_pkg::CORDIC_STEPS]),
      .res_valid (res_valid_w),
      .res_data  (res_data_w)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= res_valid_w;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= res_data_w;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

@@ tb/euler_to_basis_vectors_tb.sv @@
// testbench for euler_to_basis_vectors: random and directed angle requests, scoreboard of
// predicted basis vectors compared field by field against each response
// depends on e2bv_pkg and the euler_to_basis_vectors rtl
module euler_to_basis_vectors_tb;

   localparam int  LATENCY     = 34;
   localparam int  CYCLE_LIMIT = 400000;
   localparam int  NUM_RANDOM  = 1200;

   typedef struct packed {
      logic [15:0] roll;
      logic [15:0] yaw;
      logic [15:0] pitch;
   } angles_type;

   typedef logic [e2bv_pkg::OUT_BITS-1:0] basis_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [e2bv_pkg::IN_BITS-1:0]  req_tdata = '0;
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic [e2bv_pkg::OUT_BITS-1:0] rsp_tdata;

   angles_type pending_angles[$];
   basis_type  expected_basis[$];
   int         send_idle_pct = 26;
   int         recv_idle_pct = 69;
   bit         recv_hold = 1'b0;
   bit         send_pause = 1'b0;
   int         hold_left = 0;
   int         error_count = 0;
   int         sent_count = 0;
   int         rsp_count = 0;
   longint     cycle_count = 0;

   const string field_names[e2bv_pkg::NUM_OUT] = '{"fwd_x", "fwd_y", "fwd_z", "right_x",
                                                   "right_y", "right_z", "up_x", "up_y",
                                                   "up_z"};
   const longint atan_tab[e2bv_pkg::CORDIC_STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};

   euler_to_basis_vectors i_dut (.*);

   always #1 clock = ~clock;

   // sine and cosine in q30 via rotation-mode cordic over one quadrant
   task automatic rotate_angle(input logic [15:0] ang, output longint s, output longint c);
      logic [31:0] t;
      longint x, y, z, dx, dy;
      t = 32'(ang) << (32 - e2bv_pkg::ANGLE_BITS);
      x = 652032874;
      y = 0;
      z = longint'(t & 32'h3fff_ffff);
      for (int i = 0; i < e2bv_pkg::CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      case (t[31:30])
         2'd0: begin s = y; c = x; end
         2'd1: begin s = x; c = -y; end
         2'd2: begin s = -y; c = -x; end
         default: begin s = -x; c = y; end
      endcase
   endtask

   function automatic longint q30_product(input longint a, input longint b);
      return (a * b + (longint'(1) << 29)) >>> 30;
   endfunction

   function automatic logic [15:0] round_saturate(input longint v);
      longint r;
      longint lim;
      lim = longint'(1) << e2bv_pkg::FRAC_BITS;
      r = (v + (longint'(1) << (29 - e2bv_pkg::FRAC_BITS))) >>> (30 - e2bv_pkg::FRAC_BITS);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[15:0];
   endfunction

   // forward, right and up vectors for one set of angles
   task automatic predict_basis(input angles_type a, output basis_type b);
      longint sp, cp, sy, cy, sr, cr, spcy, spsy;
      longint v[e2bv_pkg::NUM_OUT];
      rotate_angle(a.pitch, sp, cp);
      rotate_angle(a.yaw, sy, cy);
      rotate_angle(a.roll, sr, cr);
      spcy = q30_product(sp, cy);
      spsy = q30_product(sp, sy);
      v[0] = q30_product(cp, cy);
      v[1] = q30_product(cp, sy);
      v[2] = -sp;
      v[3] = -q30_product(sr, spcy) + q30_product(cr, sy);
      v[4] = -q30_product(sr, spsy) - q30_product(cr, cy);
      v[5] = -q30_product(sr, cp);
      v[6] = q30_product(cr, spcy) + q30_product(sr, sy);
      v[7] = q30_product(cr, spsy) - q30_product(sr, cy);
      v[8] = q30_product(cr, cp);
      for (int k = 0; k < e2bv_pkg::NUM_OUT; k++) b[k*16 +: 16] = round_saturate(v[k]);
   endtask

   function automatic angles_type random_angles();
      angles_type a;
      a = angles_type'(48'({$urandom, $urandom}));
      // bias some angles toward quadrant boundaries
      if ($urandom_range(0, 3) == 0) a.pitch = 16'($urandom_range(0, 3) * 16384
                                              + $urandom_range(0, 4) - 2);
      if ($urandom_range(0, 3) == 0) a.yaw = 16'($urandom_range(0, 3) * 16384
                                            + $urandom_range(0, 4) - 2);
      return a;
   endfunction

   // request driver
   always @(posedge clock) begin
      basis_type b;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_basis(angles_type'(req_tdata), b);
            expected_basis.push_back(b);
            sent_count++;
         end
         if ((req_tvalid && !req_tready) ||
             (pending_angles.size() > 0 && !send_pause &&
              $urandom_range(0, 99) >= send_idle_pct)) begin
            if (!(req_tvalid && !req_tready)) begin
               req_tdata <= pending_angles.pop_front();
            end
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response monitor and receiver stalls
   always @(posedge clock) begin
      basis_type exp_b;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (expected_basis.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_tdata);
               error_count++;
            end else begin
               exp_b = expected_basis.pop_front();
               for (int k = 0; k < e2bv_pkg::NUM_OUT; k++) begin
                  if (rsp_tdata[k*16 +: 16] !== exp_b[k*16 +: 16]) begin
                     $error("%s expected %0d actual %0d", field_names[k],
                            $signed(exp_b[k*16 +: 16]), $signed(rsp_tdata[k*16 +: 16]));
                     error_count++;
                  end
               end
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (recv_hold) begin
            hold_left <= 200;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_angles.size() > 0 || req_tvalid || expected_basis.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: zero, quadrant boundaries, extremes, half-angles
      pending_angles.push_back('{16'h0000, 16'h0000, 16'h0000});
      pending_angles.push_back('{16'hffff, 16'hffff, 16'hffff});
      pending_angles.push_back('{16'h4000, 16'h4000, 16'h4000});
      pending_angles.push_back('{16'h8000, 16'h8000, 16'h8000});
      pending_angles.push_back('{16'hc000, 16'hc000, 16'hc000});
      pending_angles.push_back('{16'h3fff, 16'h7fff, 16'hbfff});
      pending_angles.push_back('{16'h4001, 16'h8001, 16'hc001});
      pending_angles.push_back('{16'h2000, 16'h6000, 16'ha000});
      pending_angles.push_back('{16'he000, 16'h0001, 16'h5555});
      pending_angles.push_back('{16'haaaa, 16'h5555, 16'h0000});
      pending_angles.push_back('{16'h0000, 16'h4000, 16'hffff});
      pending_angles.push_back('{16'h1000, 16'h0000, 16'hc000});
      for (int p = 0; p < 4; p++)
         pending_angles.push_back('{16'(p * 16384), 16'(p * 16384 + 8192), 16'(p * 16384)});

      // random phase one: sender sparse idles, receiver heavy idles
      for (int i = 0; i < NUM_RANDOM / 3; i++) pending_angles.push_back(random_angles());
      wait_drained();

      // long receiver hold while the sender keeps offering
      send_idle_pct = 0;
      for (int i = 0; i < 100; i++) pending_angles.push_back(random_angles());
      recv_hold = 1'b1;
      wait (hold_left > 0);
      recv_hold = 1'b0;
      wait_drained();

      // sender pauses until all results are back
      send_pause = 1'b1;
      wait_drained();
      repeat (LATENCY) @(posedge clock);
      send_pause = 1'b0;

      // random phase two: roles swapped
      send_idle_pct = 69;
      recv_idle_pct = 26;
      for (int i = 0; i < NUM_RANDOM / 3; i++) pending_angles.push_back(random_angles());
      wait_drained();

      // random phase three: no idling
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < NUM_RANDOM / 3; i++) pending_angles.push_back(random_angles());
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);

      $display("%0d angle requests sent, %0d basis results checked, %0d mismatches",
               sent_count, rsp_count, error_count);
      if (error_count == 0 && expected_basis.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
